// File: rtl/core/tile_sprite_video_processor_unit_defines.svh
// Assertion helpers for the core RTL, used by tsvp_back.
`ifndef TILE_SPRITE_VIDEO_PROCESSOR_UNIT_DEFINES_SVH
`define TILE_SPRITE_VIDEO_PROCESSOR_UNIT_DEFINES_SVH

// pre holds on an edge -> post holds on the same edge
`define TSVP_AST_IMP(lbl, pre, post) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
else $error("tsvp check failed");

// pre holds on an edge -> post holds on the next edge
`define TSVP_AST_NXT(lbl, pre, post) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
else $error("tsvp check failed");

`endif

// File: rtl/core/tsvp_pkg.sv
package tsvp_pkg;

	localparam int ADDR_W           = 14;
	localparam int VRAM_DEPTH       = 16384;
	localparam int LINE_WIDTH       = 256;
	localparam int SPRITE_ENTRIES   = 32;
	localparam int SPRITES_PER_LINE = 4;
	localparam int SHOWN_W          = $clog2(SPRITES_PER_LINE + 1);
	localparam int QDEPTH           = 2;   // power of two
	localparam int QP_W             = $clog2(QDEPTH);
	localparam int QC_W             = $clog2(QDEPTH + 1);

	localparam logic [2:0] OP_RD_DATA = 3'd0;
	localparam logic [2:0] OP_RD_STAT = 3'd1;
	localparam logic [2:0] OP_WR_DATA = 3'd2;
	localparam logic [2:0] OP_WR_CTRL = 3'd3;
	localparam logic [2:0] OP_VBLANK  = 3'd4;
	localparam logic [2:0] OP_RENDER  = 3'd5;

	localparam logic [1:0] CTRL_RD_ADDR = 2'd0;
	localparam logic [1:0] CTRL_WR_ADDR = 2'd1;

	localparam logic [7:0] SPR_END  = 8'hD0;
	localparam logic [7:0] SPR_WRAP = 8'hE0;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] value;
		logic [7:0] scanline;
	} tsvp_in_t;

	typedef struct packed {
		logic [7:0]  read_value;
		logic        irq_rise;
		logic [63:0] pixels;
		logic [3:0]  pixel_group;
		logic        last;
	} tsvp_out_t;

	// queue head seen by the back end
	typedef struct packed {
		logic     valid;
		tsvp_in_t item;
	} tsvp_q_t;

	// back end status seen by the front end
	typedef struct packed {
		logic clearing;
		logic pop;
	} tsvp_bk_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_EXEC, ST_RDWAIT, ST_FIN, ST_PUSH,
		ST_FILL, ST_T_NAME, ST_T_PAT, ST_T_COL, ST_T_LATCH, ST_T_DRAW,
		ST_S_Y, ST_S_X, ST_S_N, ST_S_A, ST_S_EVAL, ST_S_P1, ST_S_P2, ST_S_DRAW,
		ST_O_RD, ST_O_PUSH
	} tsvp_state_t;

endpackage

// File: rtl/core/tsvp_front.sv
module tsvp_front import tsvp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tsvp_in_t req,
	input  logic     req_valid,
	output logic     req_ready,
	input  tsvp_bk_t bk,
	output tsvp_q_t  q
);

	tsvp_in_t          fifo_q [QDEPTH];
	logic [QP_W-1:0]   wp_q, rp_q;
	logic [QC_W-1:0]   cnt_q;
	logic              push;

	assign req_ready = (cnt_q != QC_W'(QDEPTH)) && !bk.clearing;
	// unused op codes are dropped here
	assign push      = req_valid && req_ready && (req.op <= OP_RENDER);
	assign q.valid   = cnt_q != '0;
	assign q.item    = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (bk.pop) rp_q <= rp_q + 1'b1;
			if (push && !bk.pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && bk.pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= req;
	end

endmodule

// File: rtl/core/tsvp_back.sv
`include "tile_sprite_video_processor_unit_defines.svh"

module tsvp_back import tsvp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tsvp_q_t   q,
	output tsvp_bk_t  bk,
	output tsvp_out_t rsp,
	output logic      rsp_valid,
	input  logic      rsp_ready
);

	function automatic logic [3:0] or_bd(input logic [3:0] c, input logic [3:0] b);
		or_bd = (c != 4'd0) ? c : b;
	endfunction

	tsvp_state_t state_q, state_d;

	// video memory and line buffer
	logic [7:0]        vram [VRAM_DEPTH];
	logic [3:0]        pix [LINE_WIDTH];
	logic [ADDR_W-1:0] vaddr;
	logic              vwe;
	logic [7:0]        vwd, rdata_q;
	logic              pwe;
	logic [7:0]        pwa, pra;
	logic [3:0]        pwd, prd_q;
	logic              pop;

	// port state
	logic [7:0]        mode_q [8];
	logic [ADDR_W-1:0] acc_q, wipe_q;
	logic [7:0]        first_q, pref_q, stat_q;
	logic              held_q, irq_q;

	// current word
	logic [2:0]        op_q;
	logic [7:0]        val_q, y_q, rv_q;
	logic              rise_q;

	// render datapath
	logic [7:0]        x_q, ch_q, pat_q, cbyte_q;
	logic [5:0]        col_q;
	logic [2:0]        k_q;
	logic [4:0]        s_q, i_q, p_q;
	logic [SHOWN_W-1:0] shown_q;
	logic [7:0]        sy_q, sx_q, name_q, attr_q;
	logic [3:0]        row_q, grp_q;
	logic [15:0]       bits_q;
	logic [LINE_WIDTH-1:0] taken_q;
	logic [63:0]       word_q;

	tsvp_out_t         rsp_q;
	logic              rsp_valid_q, slot_free;

	// decode
	logic              en, txt, mc, g2m, big, mag;
	logic [3:0]        bd, tile_pix;
	logic [4:0]        row;
	logic [2:0]        sub, wlast;
	logic [5:0]        col_last;
	logic [ADDR_W-1:0] name_addr, pat_addr, col_addr, pbase, sa, sp_addr1, sp_addr2;
	logic [9:0]        idx_p, idx_c, pmask, cmask;
	logic [9:0]        sys, rowf, span, sxs, xs;
	logic              in_range, s_last, shown_full, i_last, x_ok, sbit;
	logic [3:0]        rowm, px;

	always_comb begin
		en       = mode_q[1][6];
		txt      = mode_q[1][4];
		mc       = mode_q[1][3] && !txt;
		g2m      = !txt && !mc && mode_q[0][1];
		big      = mode_q[1][1];
		mag      = mode_q[1][0];
		bd       = or_bd(mode_q[7][3:0], 4'd1);
		row      = y_q[7:3];
		sub      = y_q[2:0];
		wlast    = txt ? 3'd5 : 3'd7;
		col_last = txt ? 6'd39 : 6'd31;

		name_addr = {mode_q[2][3:0], 10'b0} + 14'(col_q)
			+ (txt ? (14'({row, 5'b0}) + 14'({row, 3'b0})) : 14'({row, 5'b0}));
		pbase = {mode_q[4][2:0], 11'b0};
		pmask = {mode_q[4][1:0], 8'hFF};
		cmask = {mode_q[3][6:0], 3'b111};
		idx_p = {row[4:3], rdata_q};
		idx_c = {row[4:3], ch_q};
		if (g2m)
			pat_addr = {mode_q[4][2], 13'b0} + 14'({idx_p & pmask, 3'b0}) + 14'(sub);
		else if (mc)
			pat_addr = pbase + 14'({rdata_q, 3'b0}) + 14'({row[1:0], y_q[2]});
		else
			pat_addr = pbase + 14'({rdata_q, 3'b0}) + 14'(sub);
		if (g2m)
			col_addr = {mode_q[3][7], 13'b0} + 14'({idx_c & cmask, 3'b0}) + 14'(sub);
		else
			col_addr = {mode_q[3], 6'b0} + 14'(ch_q[7:3]);

		if (txt)
			tile_pix = pat_q[~k_q] ? or_bd(mode_q[7][7:4], bd) : bd;
		else if (mc)
			tile_pix = !k_q[2] ? or_bd(pat_q[7:4], bd) : or_bd(pat_q[3:0], bd);
		else
			tile_pix = pat_q[~k_q] ? or_bd(cbyte_q[7:4], bd) : or_bd(cbyte_q[3:0], bd);

		// sprites: sy above the wrap point sits above the top
		sa       = {mode_q[5][6:0], 7'b0} + 14'({s_q, 2'b0});
		sys      = (sy_q > SPR_WRAP) ? {2'b11, sy_q} : {2'b00, sy_q};
		rowf     = {2'b00, y_q} - sys - 10'd1;
		span     = big ? (mag ? 10'd32 : 10'd16) : (mag ? 10'd16 : 10'd8);
		in_range = !rowf[9] && (rowf < span);
		rowm     = mag ? rowf[4:1] : rowf[3:0];
		sp_addr1 = {mode_q[6][2:0], 11'b0} + 14'(rowm)
			+ (big ? 14'({name_q[7:2], 5'b0}) : 14'({name_q, 3'b0}));
		sp_addr2 = {mode_q[6][2:0], 11'b0} + 14'({name_q[7:2], 5'b0}) + 14'(row_q) + 14'd16;
		s_last     = s_q == 5'(SPRITE_ENTRIES - 1);
		shown_full = shown_q == SHOWN_W'(SPRITES_PER_LINE);
		sxs      = {2'b00, sx_q} - (attr_q[7] ? 10'd32 : 10'd0);
		px       = mag ? i_q[4:1] : i_q[3:0];
		sbit     = bits_q[~px];
		xs       = sxs + 10'(i_q);
		x_ok     = sbit && (xs[9:8] == 2'b00);
		i_last   = i_q == 5'(span - 10'd1);
		slot_free = !rsp_valid_q || rsp_ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (wipe_q == '1) state_d = ST_IDLE;
			ST_IDLE:    if (q.valid) state_d = ST_EXEC;
			ST_EXEC: begin
				unique case (op_q)
					OP_RD_DATA: state_d = ST_RDWAIT;
					OP_WR_CTRL: state_d = (held_q && val_q[7:6] == CTRL_RD_ADDR)
						? ST_RDWAIT : ST_FIN;
					OP_RENDER:  state_d = (!en || txt) ? ST_FILL : ST_T_NAME;
					default:    state_d = ST_FIN;
				endcase
			end
			ST_RDWAIT:  state_d = ST_FIN;
			ST_FIN:     state_d = (op_q == OP_RENDER) ? ST_O_RD : ST_PUSH;
			ST_PUSH:    if (slot_free) state_d = ST_IDLE;
			ST_FILL:    if (x_q == 8'hFF) state_d = (en && txt) ? ST_T_NAME : ST_FIN;
			ST_T_NAME:  state_d = ST_T_PAT;
			ST_T_PAT:   state_d = ST_T_COL;
			ST_T_COL:   state_d = (mc || txt) ? ST_T_DRAW : ST_T_LATCH;
			ST_T_LATCH: state_d = ST_T_DRAW;
			ST_T_DRAW: begin
				if (k_q == wlast) begin
					if (col_q != col_last) state_d = ST_T_NAME;
					else state_d = txt ? ST_FIN : ST_S_Y;
				end
			end
			ST_S_Y:     state_d = ST_S_X;
			ST_S_X:     state_d = (rdata_q == SPR_END) ? ST_FIN : ST_S_N;
			ST_S_N:     state_d = ST_S_A;
			ST_S_A:     state_d = ST_S_EVAL;
			ST_S_EVAL: begin
				priority if (!in_range) state_d = s_last ? ST_FIN : ST_S_Y;
				else if (shown_full) state_d = ST_FIN;
				else state_d = ST_S_P1;
			end
			ST_S_P1:    state_d = ST_S_P2;
			ST_S_P2:    state_d = ST_S_DRAW;
			ST_S_DRAW:  if (i_last) state_d = s_last ? ST_FIN : ST_S_Y;
			ST_O_RD:    if (p_q == 5'd16) state_d = ST_O_PUSH;
			ST_O_PUSH:  if (slot_free) state_d = (grp_q == 4'hF) ? ST_IDLE : ST_O_RD;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory ports and queue pop
	always_comb begin
		vaddr = acc_q;
		vwe   = 1'b0;
		vwd   = val_q;
		pwe   = 1'b0;
		pwa   = x_q;
		pwd   = bd;
		pra   = {grp_q, p_q[3:0]};
		pop   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				vwe   = 1'b1;
				vaddr = wipe_q;
				vwd   = 8'd0;
			end
			ST_IDLE:   pop = q.valid;
			ST_EXEC: begin
				if (op_q == OP_WR_DATA) vwe = 1'b1;
				if (op_q == OP_WR_CTRL) vaddr = {val_q[5:0], first_q};
			end
			ST_FILL:   pwe = 1'b1;
			ST_T_NAME: vaddr = name_addr;
			ST_T_PAT:  vaddr = pat_addr;
			ST_T_COL:  vaddr = col_addr;
			ST_T_DRAW: begin
				pwe = 1'b1;
				pwd = tile_pix;
			end
			ST_S_Y:    vaddr = sa;
			ST_S_X:    vaddr = sa + 14'd1;
			ST_S_N:    vaddr = sa + 14'd2;
			ST_S_A:    vaddr = sa + 14'd3;
			ST_S_EVAL: vaddr = sp_addr1;
			ST_S_P1:   vaddr = sp_addr2;
			ST_S_DRAW: begin
				pwe = x_ok && !taken_q[xs[7:0]] && (attr_q[3:0] != 4'd0);
				pwa = xs[7:0];
				pwd = attr_q[3:0];
			end
			default: ;
		endcase
	end

	assign bk.pop      = pop;
	assign bk.clearing = state_q == ST_CLEAR;
	assign rsp         = rsp_q;
	assign rsp_valid   = rsp_valid_q;

	always_ff @(posedge clk) begin
		if (vwe) vram[vaddr] <= vwd;
		rdata_q <= vram[vaddr];
	end

	always_ff @(posedge clk) begin
		if (pwe) pix[pwa] <= pwd;
		prd_q <= pix[pra];
	end

	// control and port state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			wipe_q      <= '0;
			acc_q       <= '0;
			first_q     <= '0;
			held_q      <= 1'b0;
			pref_q      <= '0;
			stat_q      <= '0;
			irq_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int r = 0; r < 8; r++) mode_q[r] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) wipe_q <= wipe_q + 1'b1;
			if (state_q == ST_EXEC) begin
				unique case (op_q)
					OP_RD_DATA: begin
						held_q <= 1'b0;
						acc_q  <= acc_q + 1'b1;
					end
					OP_RD_STAT: begin
						held_q <= 1'b0;
						stat_q <= stat_q & 8'h1F;
					end
					OP_WR_DATA: begin
						held_q <= 1'b0;
						pref_q <= val_q;
						acc_q  <= acc_q + 1'b1;
					end
					OP_WR_CTRL: begin
						if (!held_q) begin
							first_q <= val_q;
							held_q  <= 1'b1;
							acc_q   <= {acc_q[13:8], val_q};
						end else begin
							held_q <= 1'b0;
							unique case (val_q[7:6])
								CTRL_RD_ADDR: acc_q <= {val_q[5:0], first_q} + 14'd1;
								CTRL_WR_ADDR: acc_q <= {val_q[5:0], first_q};
								default:      mode_q[val_q[2:0]] <= first_q;
							endcase
						end
					end
					OP_VBLANK:  stat_q[7] <= 1'b1;
					default: ;
				endcase
			end
			if (state_q == ST_RDWAIT) pref_q <= rdata_q;
			if (state_q == ST_FIN) irq_q <= stat_q[7] && mode_q[1][5];
			// fifth sprite: only the first overflow of a frame is kept
			if (state_q == ST_S_EVAL && in_range && shown_full && !stat_q[6] && !stat_q[7])
				stat_q <= {stat_q[7], 1'b1, stat_q[5], s_q};
			if (state_q == ST_S_DRAW && x_ok && taken_q[xs[7:0]]) stat_q[5] <= 1'b1;
			if ((state_q == ST_PUSH || state_q == ST_O_PUSH) && slot_free)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q <= q.item.op;
				val_q <= q.item.value;
				y_q <= q.item.scanline;
			end
			ST_EXEC: begin
				rv_q  <= (op_q == OP_RD_DATA) ? pref_q : (op_q == OP_RD_STAT) ? stat_q : 8'd0;
				x_q   <= 8'd0;
				col_q <= 6'd0;
				k_q   <= 3'd0;
			end
			ST_FIN: begin
				rise_q <= stat_q[7] && mode_q[1][5] && !irq_q;
				grp_q  <= 4'd0;
				p_q    <= 5'd0;
			end
			ST_FILL:   x_q <= (x_q == 8'hFF) ? 8'd8 : x_q + 8'd1;
			ST_T_PAT:  ch_q <= rdata_q;
			ST_T_COL:  pat_q <= rdata_q;
			ST_T_LATCH: cbyte_q <= rdata_q;
			ST_T_DRAW: begin
				x_q <= x_q + 8'd1;
				k_q <= (k_q == wlast) ? 3'd0 : k_q + 3'd1;
				if (k_q == wlast) col_q <= col_q + 6'd1;
				taken_q <= '0;
				s_q     <= 5'd0;
				shown_q <= '0;
			end
			ST_S_X:    sy_q <= rdata_q;
			ST_S_N:    sx_q <= rdata_q;
			ST_S_A:    name_q <= rdata_q;
			ST_S_EVAL: begin
				attr_q <= rdata_q;
				row_q  <= rowm;
				if (!in_range) s_q <= s_q + 5'd1;
				else if (!shown_full) shown_q <= shown_q + 1'b1;
			end
			ST_S_P1:   bits_q[15:8] <= rdata_q;
			ST_S_P2: begin
				bits_q[7:0] <= big ? rdata_q : 8'd0;
				i_q <= 5'd0;
			end
			ST_S_DRAW: begin
				i_q <= i_q + 5'd1;
				if (x_ok) taken_q[xs[7:0]] <= 1'b1;
				if (i_last) s_q <= s_q + 5'd1;
			end
			ST_O_RD: begin
				p_q <= p_q + 5'd1;
				if (p_q != 5'd0) word_q <= {prd_q, word_q[63:4]};
			end
			ST_O_PUSH: begin
				if (slot_free) begin
					grp_q <= grp_q + 4'd1;
					p_q   <= 5'd0;
				end
			end
			default: ;
		endcase
		if (state_q == ST_PUSH && slot_free)
			rsp_q <= '{read_value: rv_q, irq_rise: rise_q, pixels: 64'd0,
				pixel_group: 4'd0, last: 1'b1};
		if (state_q == ST_O_PUSH && slot_free)
			rsp_q <= '{read_value: 8'd0, irq_rise: rise_q && (grp_q == 4'd0),
				pixels: word_q, pixel_group: grp_q, last: grp_q == 4'hF};
	end

	`TSVP_AST_IMP(a_grp_last, rsp_valid_q && !rsp_q.last, rsp_q.pixel_group != 4'hF)
	`TSVP_AST_IMP(a_rise_first, rsp_valid_q && rsp_q.irq_rise, rsp_q.pixel_group == 4'd0)
	`TSVP_AST_IMP(a_clear_quiet, state_q == ST_CLEAR, !rsp_valid_q && !pop)
	`TSVP_AST_NXT(a_pop_exec, pop, state_q == ST_EXEC)

endmodule

// File: rtl/core/tile_sprite_video_processor_unit.sv
// Tile and sprite video processor with 16K of video memory behind a CPU data/control
// port pair. Words enter on req (op, value, scanline) and leave on rsp: port ops and
// vblank give one word, a render gives 16 words of 16 four-bit pixels, pixel 0 in the
// low nibble, last set on group 15. A two-word queue parts the input side from the
// sequencer, so words are taken while results wait. A render runs on one single-port
// video memory read per cycle and one line-buffer write per pixel: a backdrop fill in
// text or blanked mode; per tile a name, pattern and colour read, a colour latch
// outside multicolor and text, then its pixel writes; per sprite entry its y, x, name
// and attribute reads and an evaluation, plus two pattern reads and the pixel writes
// for each shown sprite; then the line buffer is read out one output group at a time.
// After reset the video memory is cleared, during which req_ready stays low.
module tile_sprite_video_processor_unit import tsvp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tsvp_in_t  req,
	input  logic      req_valid,
	output logic      req_ready,
	output tsvp_out_t rsp,
	output logic      rsp_valid,
	input  logic      rsp_ready
);

	// queue head toward the sequencer, pop and clear status back
	tsvp_q_t  q;
	tsvp_bk_t bk;

	// front: accepts words, drops unused op codes, queues the rest
	tsvp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.bk        (bk),
		.q         (q)
	);

	// back: port state, video memory, line renderer and output register
	tsvp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q         (q),
		.bk        (bk),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule
